// ===== design/gsla_pkg.sv =====
// shared types, codes and constants for the grid advection core
`timescale 1ns / 1ps

package gsla_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COORD_W    = 7;
    localparam int VALUE_W    = 32;
    localparam int DIM_W      = 7;
    localparam int STEP_W     = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd2;

    localparam logic [DIM_W-1:0]  GRID_WIDTH_RESET  = 7'd64;
    localparam logic [DIM_W-1:0]  GRID_HEIGHT_RESET = 7'd64;
    localparam logic [STEP_W-1:0] TIME_STEP_RESET   = 21'd6554;

    typedef struct packed {
        logic                      command;
        logic [COORD_W-1:0]        column;
        logic [COORD_W-1:0]        row;
        logic signed [VALUE_W-1:0] source_value;
        logic signed [VALUE_W-1:0] velocity_x;
        logic signed [VALUE_W-1:0] velocity_y;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] advected_value;
        logic                      is_query_result;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_SEL_A,
        OP_SEL_B,
        OP_VREAD,
        OP_WDT,
        OP_HDT,
        OP_XRAW,
        OP_YRAW,
        OP_CLAMP,
        OP_S00,
        OP_S01,
        OP_S10,
        OP_S11,
        OP_C1A,
        OP_C1B,
        OP_H0,
        OP_H1,
        OP_CELL,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        logic is_load;
        logic in_range;
        logic corner;
    } dp_status_t;

endpackage

// ===== design/grid_semi_lagrangian_advection_core.sv =====
// top level of the semi-lagrangian advection core
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_ready        item_t (command, cell, values)
//  result    out        result_valid / result_ready    result_t (advected value, flag)
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// a corner query runs the per-cell sequence twice: one shared
// multiplier and a single read port on the source grid set the per-cell sequence
// reset is asynchronous active low; grid contents are not cleared
// cfg_ready is always high; a finished result waits in its own register while
// the next item is taken
`timescale 1ns / 1ps

module grid_semi_lagrangian_advection_core #(
    parameter int MAX_WIDTH  = gsla_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsla_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = gsla_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  gsla_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output gsla_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gsla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsla_pkg::CFG_DATA_W-1:0] cfg_data
);

    gsla_pkg::dp_op_t     op;
    gsla_pkg::dp_status_t status;

    gsla_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .op           (op)
    );

    gsla_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .status    (status)
    );

endmodule

// ===== design/gsla_ctrl.sv =====
// sequencer for load, query and per-cell advection steps
`timescale 1ns / 1ps

module gsla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  gsla_pkg::dp_status_t status,
    output gsla_pkg::dp_op_t    op
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_SEL_A,
        ST_SEL_B,
        ST_VREAD,
        ST_WDT,
        ST_HDT,
        ST_XRAW,
        ST_YRAW,
        ST_CLAMP,
        ST_S00,
        ST_S01,
        ST_S10,
        ST_S11,
        ST_C1A,
        ST_C1B,
        ST_H0,
        ST_H1,
        ST_CELL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   pass_b_reg, pass_b_next;
    logic   result_valid_reg, result_valid_next;
    logic   slot_free;

    assign slot_free    = !result_valid_reg || result_ready;
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        pass_b_next       = pass_b_reg;
        result_valid_next = result_valid_reg && !result_ready;
        op                = gsla_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op         = gsla_pkg::OP_LATCH;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                pass_b_next = 1'b0;
                if (status.is_load)
                    state_next = ST_LOAD;
                else if (!status.in_range)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SEL_A;
            end
            ST_LOAD:
            begin
                op         = gsla_pkg::OP_LOAD;
                state_next = ST_FINISH;
            end
            ST_SEL_A:
            begin
                op         = gsla_pkg::OP_SEL_A;
                state_next = ST_VREAD;
            end
            ST_SEL_B:
            begin
                op         = gsla_pkg::OP_SEL_B;
                state_next = ST_VREAD;
            end
            ST_VREAD:
            begin
                op         = gsla_pkg::OP_VREAD;
                state_next = ST_WDT;
            end
            ST_WDT:
            begin
                op         = gsla_pkg::OP_WDT;
                state_next = ST_HDT;
            end
            ST_HDT:
            begin
                op         = gsla_pkg::OP_HDT;
                state_next = ST_XRAW;
            end
            ST_XRAW:
            begin
                op         = gsla_pkg::OP_XRAW;
                state_next = ST_YRAW;
            end
            ST_YRAW:
            begin
                op         = gsla_pkg::OP_YRAW;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                op         = gsla_pkg::OP_CLAMP;
                state_next = ST_S00;
            end
            ST_S00:
            begin
                op         = gsla_pkg::OP_S00;
                state_next = ST_S01;
            end
            ST_S01:
            begin
                op         = gsla_pkg::OP_S01;
                state_next = ST_S10;
            end
            ST_S10:
            begin
                op         = gsla_pkg::OP_S10;
                state_next = ST_S11;
            end
            ST_S11:
            begin
                op         = gsla_pkg::OP_S11;
                state_next = ST_C1A;
            end
            ST_C1A:
            begin
                op         = gsla_pkg::OP_C1A;
                state_next = ST_C1B;
            end
            ST_C1B:
            begin
                op         = gsla_pkg::OP_C1B;
                state_next = ST_H0;
            end
            ST_H0:
            begin
                op         = gsla_pkg::OP_H0;
                state_next = ST_H1;
            end
            ST_H1:
            begin
                op         = gsla_pkg::OP_H1;
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                op = gsla_pkg::OP_CELL;
                // a corner runs a second cell, then averages
                if (status.corner && !pass_b_reg)
                begin
                    pass_b_next = 1'b1;
                    state_next  = ST_SEL_B;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    op                = gsla_pkg::OP_RESULT;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pass_b_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pass_b_reg       <= pass_b_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ===== design/gsla_datapath.sv =====
// grid memories, config registers, shared multiplier and interpolation datapath
`timescale 1ns / 1ps

module gsla_datapath #(
    parameter int MAX_WIDTH  = gsla_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsla_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = gsla_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gsla_pkg::item_t                     item,
    output gsla_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gsla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsla_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  gsla_pkg::dp_op_t                    op,
    output gsla_pkg::dp_status_t                status
);

    localparam int STRIDE = MAX_WIDTH + 2;
    localparam int DEPTH  = STRIDE * (MAX_HEIGHT + 2);
    localparam int AW     = $clog2(DEPTH);
    localparam int CWX    = ($clog2(MAX_WIDTH + 2) > gsla_pkg::COORD_W) ?
                            $clog2(MAX_WIDTH + 2) : gsla_pkg::COORD_W;
    localparam int CW     = ($clog2(MAX_HEIGHT + 2) > CWX) ? $clog2(MAX_HEIGHT + 2) : CWX;
    localparam int MA     = (CW + gsla_pkg::STEP_W + 1 > FRAC_BITS + 2) ?
                            CW + gsla_pkg::STEP_W + 1 : FRAC_BITS + 2;
    localparam int VW     = gsla_pkg::VALUE_W;
    localparam int PW     = MA + VW;
    localparam int CF     = CW + FRAC_BITS;
    localparam int DTW    = CW + gsla_pkg::STEP_W;
    localparam logic [CW-1:0] LOAD_COL_MAX = CW'(MAX_WIDTH + 1);
    localparam logic [CW-1:0] LOAD_ROW_MAX = CW'(MAX_HEIGHT + 1);
    localparam logic [CW-1:0] DIM_MAX_W    = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] DIM_MAX_H    = CW'(MAX_HEIGHT);
    localparam logic [CW-1:0] ONE_C        = CW'(1);
    localparam logic [FRAC_BITS:0] ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PW:0] HALF    = (PW+1)'(1) <<< (FRAC_BITS - 1);

    // config registers
    logic [gsla_pkg::DIM_W-1:0]  grid_width_reg, grid_height_reg;
    logic [gsla_pkg::STEP_W-1:0] time_step_reg;

    // storage
    logic signed [VW-1:0] src_mem [DEPTH];
    logic signed [VW-1:0] vx_mem  [DEPTH];
    logic signed [VW-1:0] vy_mem  [DEPTH];
    logic signed [VW-1:0] src_rd_reg, vx_rd_reg, vy_rd_reg;

    // working registers
    gsla_pkg::item_t      item_reg;
    gsla_pkg::result_t    result_reg;
    logic [CW-1:0]        cc_reg, cr_reg;
    logic [DTW-1:0]       wdt_reg, hdt_reg;
    logic signed [PW:0]   x_raw_reg, y_raw_reg;
    logic [CF-1:0]        x_reg, y_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;
    logic signed [VW-1:0] col0_reg, col1_reg, cell_reg, a_reg;

    // decoded item
    logic [CW-1:0] w_eff, h_eff, w_in, h_in, col, row;
    logic [CW-1:0] wrap_col, wrap_row;
    logic          col_edge, row_edge, load_ok;

    logic signed [MA-1:0] mul_a;
    logic signed [VW-1:0] mul_b;
    logic signed [PW-1:0] prod_sh;
    logic signed [PW:0]   coord_x, coord_y, sum_ap, sum_sh, hi_x, hi_y, x_c, y_c;
    logic [CW-1:0]        i0, j0, i1, j1;
    logic [FRAC_BITS-1:0] s1, t1;
    logic [FRAC_BITS:0]   s0, t0;
    logic [AW-1:0]        src_addr, item_addr, cell_addr_q;
    logic signed [VW:0]   avg_sum;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                input logic [CW-1:0] r);
        cell_addr = AW'(int'(r) * STRIDE + int'(c));
    endfunction

    assign cfg_ready = 1'b1;
    assign result    = result_reg;

    // effective dimensions: zero means one, large values saturate
    assign w_in  = CW'(grid_width_reg);
    assign h_in  = CW'(grid_height_reg);
    assign w_eff = (w_in == '0) ? ONE_C : ((w_in > DIM_MAX_W) ? DIM_MAX_W : w_in);
    assign h_eff = (h_in == '0) ? ONE_C : ((h_in > DIM_MAX_H) ? DIM_MAX_H : h_in);

    assign col      = CW'(item_reg.column);
    assign row      = CW'(item_reg.row);
    assign col_edge = (col == '0) || (col == w_eff + ONE_C);
    assign row_edge = (row == '0) || (row == h_eff + ONE_C);
    assign wrap_col = (col == '0) ? w_eff : ((col == w_eff + ONE_C) ? ONE_C : col);
    assign wrap_row = (row == '0) ? h_eff : ((row == h_eff + ONE_C) ? ONE_C : row);
    assign load_ok  = (col <= LOAD_COL_MAX) && (row <= LOAD_ROW_MAX);

    assign status.is_load  = (item_reg.command == gsla_pkg::CMD_LOAD);
    assign status.in_range = (col <= w_eff + ONE_C) && (row <= h_eff + ONE_C);
    assign status.corner   = col_edge && row_edge;

    assign i0 = x_reg[CF-1:FRAC_BITS];
    assign j0 = y_reg[CF-1:FRAC_BITS];
    assign i1 = i0 + ONE_C;
    assign j1 = j0 + ONE_C;
    assign s1 = x_reg[FRAC_BITS-1:0];
    assign t1 = y_reg[FRAC_BITS-1:0];
    assign s0 = ONE_F - {1'b0, s1};
    assign t0 = ONE_F - {1'b0, t1};

    assign item_addr   = cell_addr(col, row);
    assign cell_addr_q = cell_addr(cc_reg, cr_reg);

    // back-trace: coordinate minus floor of the scaled displacement
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign coord_x = $signed((PW+1)'({cc_reg, {FRAC_BITS{1'b0}}})) - (PW+1)'(prod_sh);
    assign coord_y = $signed((PW+1)'({cr_reg, {FRAC_BITS{1'b0}}})) - (PW+1)'(prod_sh);

    assign hi_x = $signed((PW+1)'({w_eff, {FRAC_BITS{1'b0}}})) + HALF;
    assign hi_y = $signed((PW+1)'({h_eff, {FRAC_BITS{1'b0}}})) + HALF;
    assign x_c  = (x_raw_reg < HALF) ? HALF : ((x_raw_reg > hi_x) ? hi_x : x_raw_reg);
    assign y_c  = (y_raw_reg < HALF) ? HALF : ((y_raw_reg > hi_y) ? hi_y : y_raw_reg);

    assign sum_ap  = (PW+1)'(acc_reg) + (PW+1)'(prod_reg);
    assign sum_sh  = sum_ap >>> FRAC_BITS;
    assign avg_sum = (VW+1)'(a_reg) + (VW+1)'(cell_reg);

    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        src_addr = cell_addr(i0, j0);
        case (op)
            gsla_pkg::OP_VREAD:
            begin
                mul_a = MA'(w_eff);
                mul_b = VW'(time_step_reg);
            end
            gsla_pkg::OP_WDT:
            begin
                mul_a = MA'(h_eff);
                mul_b = VW'(time_step_reg);
            end
            gsla_pkg::OP_HDT:
            begin
                mul_a = MA'(wdt_reg);
                mul_b = vx_rd_reg;
            end
            gsla_pkg::OP_XRAW:
            begin
                mul_a = MA'(hdt_reg);
                mul_b = vy_rd_reg;
            end
            gsla_pkg::OP_S01:
            begin
                mul_a    = MA'(t0);
                mul_b    = src_rd_reg;
                src_addr = cell_addr(i0, j1);
            end
            gsla_pkg::OP_S10:
            begin
                mul_a    = MA'(t1);
                mul_b    = src_rd_reg;
                src_addr = cell_addr(i1, j0);
            end
            gsla_pkg::OP_S11:
            begin
                mul_a    = MA'(t0);
                mul_b    = src_rd_reg;
                src_addr = cell_addr(i1, j1);
            end
            gsla_pkg::OP_C1A:
            begin
                mul_a = MA'(t1);
                mul_b = src_rd_reg;
            end
            gsla_pkg::OP_H0:
            begin
                mul_a = MA'(s0);
                mul_b = col0_reg;
            end
            gsla_pkg::OP_H1:
            begin
                mul_a = MA'(s1);
                mul_b = col1_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gsla_pkg::GRID_WIDTH_RESET;
            grid_height_reg <= gsla_pkg::GRID_HEIGHT_RESET;
            time_step_reg   <= gsla_pkg::TIME_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gsla_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[gsla_pkg::DIM_W-1:0];
                gsla_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[gsla_pkg::DIM_W-1:0];
                gsla_pkg::CFG_TIME_STEP:   time_step_reg   <= cfg_data;
                default:                   time_step_reg   <= time_step_reg;
            endcase
        end
    end

    // grid memories, one write or read port each
    always_ff @(posedge clk)
    begin
        if (op == gsla_pkg::OP_LOAD && load_ok)
        begin
            src_mem[item_addr] <= item_reg.source_value;
            vx_mem[item_addr]  <= item_reg.velocity_x;
            vy_mem[item_addr]  <= item_reg.velocity_y;
        end
        if (op == gsla_pkg::OP_VREAD)
        begin
            vx_rd_reg <= vx_mem[cell_addr_q];
            vy_rd_reg <= vy_mem[cell_addr_q];
        end
        if (op == gsla_pkg::OP_S00 || op == gsla_pkg::OP_S01 ||
            op == gsla_pkg::OP_S10 || op == gsla_pkg::OP_S11)
        begin
            src_rd_reg <= src_mem[src_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (op)
            gsla_pkg::OP_LATCH: item_reg <= item;
            gsla_pkg::OP_SEL_A:
            begin
                cc_reg <= status.corner ? ((col == '0) ? ONE_C : w_eff) : wrap_col;
                cr_reg <= wrap_row;
            end
            gsla_pkg::OP_SEL_B:
            begin
                a_reg  <= cell_reg;
                cc_reg <= wrap_col;
                cr_reg <= (row == '0) ? ONE_C : h_eff;
            end
            gsla_pkg::OP_WDT:   wdt_reg   <= prod_reg[DTW-1:0];
            gsla_pkg::OP_HDT:   hdt_reg   <= prod_reg[DTW-1:0];
            gsla_pkg::OP_XRAW:  x_raw_reg <= coord_x;
            gsla_pkg::OP_YRAW:  y_raw_reg <= coord_y;
            gsla_pkg::OP_CLAMP:
            begin
                x_reg <= x_c[CF-1:0];
                y_reg <= y_c[CF-1:0];
            end
            gsla_pkg::OP_S10:   acc_reg  <= prod_reg;
            gsla_pkg::OP_S11:   col0_reg <= sum_sh[VW-1:0];
            gsla_pkg::OP_C1A:   acc_reg  <= prod_reg;
            gsla_pkg::OP_C1B:   col1_reg <= sum_sh[VW-1:0];
            gsla_pkg::OP_H1:    acc_reg  <= prod_reg;
            gsla_pkg::OP_CELL:  cell_reg <= sum_sh[VW-1:0];
            gsla_pkg::OP_RESULT:
            begin
                result_reg.is_query_result <= !status.is_load;
                if (status.is_load || !status.in_range)
                    result_reg.advected_value <= '0;
                else if (status.corner)
                    result_reg.advected_value <= avg_sum[VW:1];
                else
                    result_reg.advected_value <= cell_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the semi-lagrangian advection core
`timescale 1ns / 1ps

module testbench;

    localparam int STRIDE    = 66;
    localparam int DEPTH     = 66 * 66;
    localparam int FB        = 16;
    localparam int IDLE_MAX  = 20000;
    localparam int SETTLE    = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            item_valid;
    logic                            item_ready;
    gsla_pkg::item_t                 item;
    logic                            result_valid;
    logic                            result_ready;
    gsla_pkg::result_t               result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gsla_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gsla_pkg::CFG_DATA_W-1:0] cfg_data;

    grid_semi_lagrangian_advection_core uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the grids and registers
    logic signed [31:0] src_mem [DEPTH];
    logic signed [31:0] vx_mem  [DEPTH];
    logic signed [31:0] vy_mem  [DEPTH];
    int unsigned        width_reg;
    int unsigned        height_reg;
    longint             step_reg;
    int unsigned        eff_w;
    int unsigned        eff_h;

    gsla_pkg::result_t  pending_results [$];
    int                 fail_count;
    int                 burst_left;
    int                 idle_cycles;
    int                 stall_mode;
    int                 stall_timer;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic longint clamp_pos(input longint p, input int unsigned n);
        longint half;
        longint hi;
        half = longint'(1) << (FB - 1);
        hi = (longint'(n) << FB) + half;
        if (p < half) p = half;
        if (p > hi) p = hi;
        return p;
    endfunction

    function automatic int unsigned mirror(input int unsigned p, input int unsigned n);
        if (p == 0) return n;
        if (p == n + 1) return 1;
        return p;
    endfunction

    // bilinear back-traced value of one interior cell
    function automatic longint traced_value(input int unsigned c, input int unsigned r);
        longint one;
        longint x;
        longint y;
        longint s1;
        longint t1;
        longint col0;
        longint col1;
        int unsigned i0;
        int unsigned j0;
        int a;
        one = longint'(1) << FB;
        a = r * STRIDE + c;
        x = (longint'(c) << FB) - ((longint'(eff_w) * step_reg * longint'(vx_mem[a])) >>> FB);
        y = (longint'(r) << FB) - ((longint'(eff_h) * step_reg * longint'(vy_mem[a])) >>> FB);
        x = clamp_pos(x, eff_w);
        y = clamp_pos(y, eff_h);
        i0 = int'(x >>> FB);
        j0 = int'(y >>> FB);
        s1 = x & (one - 1);
        t1 = y & (one - 1);
        col0 = ((one - t1) * longint'(src_mem[j0 * STRIDE + i0])
            + t1 * longint'(src_mem[(j0 + 1) * STRIDE + i0])) >>> FB;
        col1 = ((one - t1) * longint'(src_mem[j0 * STRIDE + i0 + 1])
            + t1 * longint'(src_mem[(j0 + 1) * STRIDE + i0 + 1])) >>> FB;
        return ((one - s1) * col0 + s1 * col1) >>> FB;
    endfunction

    function automatic gsla_pkg::result_t advect_predict(input gsla_pkg::item_t it);
        gsla_pkg::result_t res;
        int unsigned       c;
        int unsigned       r;
        int                a;
        longint            va;
        longint            vb;
        bit                col_edge;
        bit                row_edge;
        c = it.column;
        r = it.row;
        res.advected_value = '0;
        res.is_query_result = 1'b0;
        if (it.command == gsla_pkg::CMD_LOAD)
        begin
            if (c <= 65 && r <= 65)
            begin
                a = r * STRIDE + c;
                src_mem[a] = it.source_value;
                vx_mem[a] = it.velocity_x;
                vy_mem[a] = it.velocity_y;
            end
            return res;
        end
        res.is_query_result = 1'b1;
        if (c <= eff_w + 1 && r <= eff_h + 1)
        begin
            col_edge = (c == 0 || c == eff_w + 1);
            row_edge = (r == 0 || r == eff_h + 1);
            if (col_edge && row_edge)
            begin
                // corner: mean of the two neighboring edge cells
                va = traced_value(c == 0 ? 1 : eff_w, mirror(r, eff_h));
                vb = traced_value(mirror(c, eff_w), r == 0 ? 1 : eff_h);
                res.advected_value = 32'((va + vb) >>> 1);
            end
            else
                res.advected_value = 32'(traced_value(mirror(c, eff_w), mirror(r, eff_h)));
        end
        return res;
    endfunction

    // caller sits at a rising edge; returns at the edge that accepts the item
    task automatic send_item(input gsla_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        pending_results.push_back(advect_predict(it));
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gsla_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= gsla_pkg::CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == gsla_pkg::CFG_GRID_WIDTH) width_reg = data & 32'h7f;
        else if (idx == gsla_pkg::CFG_GRID_HEIGHT) height_reg = data & 32'h7f;
        else if (idx == gsla_pkg::CFG_TIME_STEP) step_reg = data & 32'h1fffff;
        eff_w = (width_reg == 0) ? 1 : (width_reg > 64 ? 64 : width_reg);
        eff_h = (height_reg == 0) ? 1 : (height_reg > 64 ? 64 : height_reg);
    endtask

    task automatic set_grid(input int unsigned w, input int unsigned h, input int unsigned dt);
        wait_idle();
        write_reg(gsla_pkg::CFG_GRID_WIDTH, w);
        write_reg(gsla_pkg::CFG_GRID_HEIGHT, h);
        write_reg(gsla_pkg::CFG_TIME_STEP, dt);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_velocity();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
    endfunction

    function automatic gsla_pkg::item_t make_item(input logic cmd, input int unsigned c,
                                                  input int unsigned r);
        gsla_pkg::item_t it;
        it.command = cmd;
        it.column = gsla_pkg::COORD_W'(c);
        it.row = gsla_pkg::COORD_W'(r);
        it.source_value = $urandom;
        it.velocity_x = rand_velocity();
        it.velocity_y = rand_velocity();
        return it;
    endfunction

    // writes every padded cell that a query of the current grid can read
    task automatic fill_grid();
        for (int r = 0; r <= eff_h + 1; r++)
            for (int c = 0; c <= eff_w + 1; c++)
                send_item(make_item(gsla_pkg::CMD_LOAD, c, r));
    endtask

    task automatic test_directed();
        gsla_pkg::item_t it;
        set_grid(2, 2, 6554);
        fill_grid();
        // extreme source and velocity values at one cell, zero velocity at another
        it = make_item(gsla_pkg::CMD_LOAD, 1, 1);
        it.source_value = 32'h8000_0000;
        it.velocity_x = 32'h7fff_ffff;
        it.velocity_y = 32'h8000_0000;
        send_item(it);
        it = make_item(gsla_pkg::CMD_LOAD, 2, 2);
        it.source_value = 32'h7fff_ffff;
        it.velocity_x = '0;
        it.velocity_y = '0;
        send_item(it);
        send_item(make_item(gsla_pkg::CMD_QUERY, 1, 1));
        send_item(make_item(gsla_pkg::CMD_QUERY, 2, 2));
        // corners, then edges
        send_item(make_item(gsla_pkg::CMD_QUERY, 0, 0));
        send_item(make_item(gsla_pkg::CMD_QUERY, 3, 0));
        send_item(make_item(gsla_pkg::CMD_QUERY, 0, 3));
        send_item(make_item(gsla_pkg::CMD_QUERY, 3, 3));
        send_item(make_item(gsla_pkg::CMD_QUERY, 0, 1));
        send_item(make_item(gsla_pkg::CMD_QUERY, 2, 3));
        // outside the grid, and loads outside the store
        send_item(make_item(gsla_pkg::CMD_QUERY, 4, 1));
        send_item(make_item(gsla_pkg::CMD_QUERY, 127, 127));
        send_item(make_item(gsla_pkg::CMD_LOAD, 127, 127));
        send_item(make_item(gsla_pkg::CMD_LOAD, 66, 0));
        send_item(make_item(gsla_pkg::CMD_QUERY, 1, 2));
    endtask

    task automatic test_random(input int unsigned w, input int unsigned h,
                               input int unsigned dt, input int count);
        int unsigned c;
        int unsigned r;
        set_grid(w, h, dt);
        fill_grid();
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c = $urandom_range(0, 127);
                r = $urandom_range(0, 127);
            end
            else
            begin
                c = $urandom_range(0, eff_w + 1);
                r = $urandom_range(0, eff_h + 1);
            end
            send_item(make_item($urandom_range(0, 9) < 7 ? gsla_pkg::CMD_QUERY
                                                         : gsla_pkg::CMD_LOAD, c, r));
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", result, 0);
            else
            begin
                if (result.advected_value !== pending_results[0].advected_value)
                    report("advected_value", result.advected_value,
                           pending_results[0].advected_value);
                if (result.is_query_result !== pending_results[0].is_query_result)
                    report("is_query_result", result.is_query_result,
                           pending_results[0].is_query_result);
                void'(pending_results.pop_front());
            end
        end
    end

    // receiver stalls: always ready, random, or mostly stalled
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 120);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= $urandom_range(0, 1);
            default: result_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("grid_semi_lagrangian_advection_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        burst_left = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_timer = 0;
        width_reg = 64;
        height_reg = 64;
        step_reg = 6554;
        eff_w = 64;
        eff_h = 64;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 127, 0, 80);
        test_random(127, 0, 2097151, 80);
        test_random(5, 3, 6554, 120);
        test_random(8, 6, 1048576, 120);
        test_random(3, 7, $urandom_range(0, 1048576), 120);
        test_random(1, 1, 32768, 80);
        wait_idle();
        if (fail_count == 0)
            $display("grid_semi_lagrangian_advection_core: match");
        else
            $display("grid_semi_lagrangian_advection_core: mismatch");
        $finish;
    end

endmodule
